// File: rtl/smc_pkg.sv
// Shared types and constants for the settable minute clock.
`timescale 1ns / 1ps
`default_nettype none

package smc_pkg;

    localparam int unsigned DEF_TICKS_PER_MINUTE = 60;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BUTTON_W = 4;
    localparam int unsigned MINUTE_W = 11;
    localparam int unsigned TICK_W   = 6;
    localparam int unsigned LED_W    = 8;
    localparam int unsigned HOURS_W  = 5;
    localparam int unsigned MINS_W   = 6;

    localparam logic [MINUTE_W-1:0] DAY_MINUTES  = 11'd1440;
    localparam logic [MINUTE_W-1:0] HOUR_MINUTES = 11'd60;

    localparam logic [LED_W-1:0] LED_RUN  = 8'b1000_0000;
    localparam logic [LED_W-1:0] LED_SWAP = 8'b0011_0000;
    localparam logic [LED_W-1:0] LED_LOW  = 8'b0001_0000;
    localparam logic [LED_W-1:0] LED_SET  = 8'b0010_0000;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd2;

    localparam logic [BUTTON_W-1:0] BTN_TOGGLE = 4'd1;
    localparam logic [BUTTON_W-1:0] BTN_RELOAD = 4'd2;
    localparam logic [BUTTON_W-1:0] BTN_HOUR   = 4'd3;
    localparam logic [BUTTON_W-1:0] BTN_MINUTE = 4'd4;

    // floor(m / 60) == (m * 1093) >> 16 for every m below 1440
    localparam int unsigned          DIV60_SHIFT = 16;
    localparam logic [MINUTE_W-1:0]  DIV60_MUL   = 11'd1093;

    typedef enum logic [1:0] {
        UPD_INIT    = 2'd0,
        UPD_LED     = 2'd1,
        UPD_DISPLAY = 2'd2,
        UPD_BOTH    = 2'd3
    } t_update_kind;

endpackage

`default_nettype wire

// File: rtl/settable_minute_clock_core.sv
// Minute-of-day clock with set mode: top level, state update and result register.
//
// The block takes one beat per cycle while its input is not stalled. A beat
// lands in an input register, the clock state is updated from it and any
// result is written to the output register. Once the clock has started,
// ticks outside set mode that do not complete a minute, multiple presses or
// unknown buttons and kind three update state (or not) and give no result.
// The input stalls only while the waiting beat has a result and the output
// register holds a result that is itself stalled.
`timescale 1ns / 1ps
`default_nettype none

module settable_minute_clock_core
    import smc_pkg::*;
#(
    parameter int unsigned TICKS_PER_MINUTE = DEF_TICKS_PER_MINUTE
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [BUTTON_W-1:0]  i_button_id,
    input  wire logic                 i_multi_press,
    input  wire logic [MINUTE_W-1:0]  i_board_minute,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [1:0]           o_update_kind,
    output logic      [LED_W-1:0]     o_led_pattern,
    output logic      [HOURS_W-1:0]   o_show_hours,
    output logic      [MINS_W-1:0]    o_show_minutes
);

    localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(TICKS_PER_MINUTE);

    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [BUTTON_W-1:0] r_in_button;
    logic                r_in_multi;
    logic [MINUTE_W-1:0] r_in_board;

    logic                r_started,  n_started;
    logic                r_setting,  n_setting;
    logic [TICK_W-1:0]   r_tick,     n_tick;
    logic [MINUTE_W-1:0] r_current,  n_current;
    logic [MINUTE_W-1:0] r_edit,     n_edit;
    logic [LED_W-1:0]    r_led,      n_led;

    logic                r_out_valid;
    t_update_kind        r_out_kind;
    logic [LED_W-1:0]    r_out_led;
    logic [HOURS_W-1:0]  r_out_hours;
    logic [MINS_W-1:0]   r_out_mins;

    logic                has_result;
    t_update_kind        res_kind;
    logic [MINUTE_W-1:0] board_day;
    logic [MINUTE_W-1:0] cur_inc;
    logic [MINUTE_W-1:0] edit_hour;
    logic [MINUTE_W-1:0] edit_min;
    logic [TICK_W-1:0]   tick_inc;
    logic [LED_W-1:0]    led_base;
    logic [MINUTE_W-1:0] shown;
    logic [HOURS_W-1:0]  shown_hours;
    logic [MINS_W-1:0]   shown_mins;
    logic                advance;

    always_comb begin
        board_day = (r_in_board >= DAY_MINUTES) ? r_in_board - DAY_MINUTES : r_in_board;
        cur_inc   = (r_current + 11'd1 >= DAY_MINUTES) ? '0 : r_current + 11'd1;
        edit_hour = (r_edit + HOUR_MINUTES >= DAY_MINUTES) ?
                    r_edit + HOUR_MINUTES - DAY_MINUTES : r_edit + HOUR_MINUTES;
        edit_min  = (r_edit + 11'd1 >= DAY_MINUTES) ? '0 : r_edit + 11'd1;
        tick_inc  = r_tick + 6'd1;
        led_base  = (r_led == LED_RUN) ? LED_LOW : r_led;

        n_started  = r_started;
        n_setting  = r_setting;
        n_tick     = r_tick;
        n_current  = r_current;
        n_edit     = r_edit;
        n_led      = r_led;
        has_result = 1'b0;
        res_kind   = UPD_INIT;

        if (!r_started || r_in_kind == KIND_INIT) begin
            if (!r_started) begin
                n_current = board_day;
            end
            n_started  = 1'b1;
            n_led      = LED_RUN;
            n_setting  = 1'b0;
            has_result = 1'b1;
            res_kind   = UPD_INIT;
        end else if (r_in_kind == KIND_TICK) begin
            if (r_setting) begin
                n_led      = led_base ^ LED_SWAP;
                has_result = 1'b1;
                res_kind   = UPD_LED;
            end else if (tick_inc >= TICK_LIMIT) begin
                n_tick     = '0;
                n_current  = cur_inc;
                has_result = 1'b1;
                res_kind   = UPD_DISPLAY;
            end else begin
                n_tick = tick_inc;
            end
        end else if (r_in_kind == KIND_BUTTON && !r_in_multi) begin
            res_kind = UPD_BOTH;
            case (r_in_button)
                BTN_TOGGLE: begin
                    has_result = 1'b1;
                    n_setting  = !r_setting;
                    n_tick     = '0;
                    if (r_setting) begin
                        n_current = r_edit;
                        n_led     = LED_RUN;
                    end else begin
                        n_edit = r_current;
                        n_led  = LED_SET;
                    end
                end
                BTN_RELOAD: begin
                    has_result = 1'b1;
                    n_edit     = board_day;
                end
                BTN_HOUR: begin
                    has_result = 1'b1;
                    n_edit     = edit_hour;
                end
                BTN_MINUTE: begin
                    has_result = 1'b1;
                    n_edit     = edit_min;
                end
                default: begin
                    has_result = 1'b0;
                end
            endcase
        end

        shown = n_setting ? n_edit : n_current;
    end

    smc_time_split u_split (
        .i_minute  (shown),
        .o_hours   (shown_hours),
        .o_minutes (shown_mins)
    );

    assign advance    = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_kind   <= i_kind;
            r_in_button <= i_button_id;
            r_in_multi  <= i_multi_press;
            r_in_board  <= i_board_minute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_setting <= 1'b0;
            r_tick    <= '0;
            r_current <= '0;
            r_edit    <= '0;
            r_led     <= LED_RUN;
        end else if (advance) begin
            r_started <= n_started;
            r_setting <= n_setting;
            r_tick    <= n_tick;
            r_current <= n_current;
            r_edit    <= n_edit;
            r_led     <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out_kind  <= res_kind;
            r_out_led   <= n_led;
            r_out_hours <= shown_hours;
            r_out_mins  <= shown_mins;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_update_kind  = r_out_kind;
    assign o_led_pattern  = r_out_led;
    assign o_show_hours   = r_out_hours;
    assign o_show_minutes = r_out_mins;

    a_current_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_current < DAY_MINUTES)
        else $error("current minute left the day range");

    a_edit_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edit < DAY_MINUTES)
        else $error("edit minute left the day range");

    a_tick_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < TICK_LIMIT)
        else $error("tick count reached the minute limit");

    a_set_holds_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_setting |-> r_tick == '0)
        else $error("tick count moved in set mode");

    a_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_started)
        else $error("result present before the clock started");

    a_init_leaves_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && has_result && res_kind == UPD_INIT |=> !r_setting)
        else $error("init beat left set mode active");

endmodule

`default_nettype wire

// File: rtl/smc_time_split.sv
// Splits a minute of the day into hours and minutes.
`timescale 1ns / 1ps
`default_nettype none

module smc_time_split
    import smc_pkg::*;
(
    input  wire logic [MINUTE_W-1:0] i_minute,
    output logic      [HOURS_W-1:0]  o_hours,
    output logic      [MINS_W-1:0]   o_minutes
);

    localparam int unsigned PROD_W = 2 * MINUTE_W;

    logic [PROD_W-1:0]   prod;
    logic [MINUTE_W-1:0] hour_base;

    always_comb begin
        prod      = PROD_W'(i_minute) * PROD_W'(DIV60_MUL);
        o_hours   = prod[DIV60_SHIFT +: HOURS_W];
        hour_base = MINUTE_W'(o_hours) * HOUR_MINUTES;
        o_minutes = MINS_W'(i_minute - hour_base);
    end

endmodule

`default_nettype wire
